@@ design/amcs_pkg.sv @@
// ----------------------------------------------------------------------------
// amcs_pkg
// Shared types, constants and helpers for the AVI movi chunk scanner.
// ----------------------------------------------------------------------------
package amcs_pkg;

    // Width of the running file offset
    localparam int OFFSET_BITS = 31;
    localparam int POS_W       = OFFSET_BITS;
    localparam int CFG_POS_W   = 31;
    localparam int FIELD_POS_W = 31;
    localparam int SIZE_W      = 32;
    localparam int TAG_W       = 32;
    // payload offset + size + pad, with room for the carry
    localparam int SUM_W       = ((POS_W > SIZE_W) ? POS_W : SIZE_W) + 1;
    localparam int SKIP_W      = SIZE_W + 1;
    localparam int CMP_W       = (POS_W > CFG_POS_W) ? POS_W : CFG_POS_W;

    // Configuration port
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam logic [1:0] REG_WANTED_STREAM = 2'd0;
    localparam logic [1:0] REG_PACKET_KIND   = 2'd1;
    localparam logic [1:0] REG_MOVI_START    = 2'd2;
    localparam logic [1:0] REG_MOVI_END      = 2'd3;

    localparam logic [7:0] NO_STREAM = 8'd255;
    localparam logic       KIND_VIDEO = 1'b0;

    // Event codes
    localparam logic [1:0] EV_PACKET    = 2'd0;
    localparam logic [1:0] EV_END       = 2'd1;
    localparam logic [1:0] EV_FORMAT    = 2'd2;
    localparam logic [1:0] EV_RANGE     = 2'd3;

    // FourCCs, little-endian
    localparam logic [TAG_W-1:0] TAG_LIST = 32'h5453_494C;
    localparam logic [TAG_W-1:0] TAG_REC  = 32'h2063_6572;

    // Characters
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_F  = 8'h46;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_LC_D  = 8'h64;
    localparam logic [7:0] CH_LC_C  = 8'h63;
    localparam logic [7:0] CH_LC_B  = 8'h62;
    localparam logic [7:0] CH_LC_W  = 8'h77;

    typedef struct packed {
        logic                   ok;
        logic [3:0]             value;
    } t_hex;

    typedef struct packed {
        logic [1:0]             event_code;
        logic [TAG_W-1:0]       chunk_tag;
        logic [SIZE_W-1:0]      payload_length;
        logic [FIELD_POS_W-1:0] payload_position;
        logic [FIELD_POS_W-1:0] next_position;
    } t_result;

    // ASCII hex digit to nibble
    function automatic t_hex hex_digit(input logic [7:0] c);
        t_hex h;
        h = '0;
        if (c >= CH_0 && c <= CH_9) begin
            h.ok    = 1'b1;
            h.value = 4'(c - CH_0);
        end else if (c >= CH_UC_A && c <= CH_UC_F) begin
            h.ok    = 1'b1;
            h.value = 4'(c - CH_UC_A + 8'd10);
        end else if (c >= CH_LC_A && c <= CH_LC_F) begin
            h.ok    = 1'b1;
            h.value = 4'(c - CH_LC_A + 8'd10);
        end
        return h;
    endfunction

    // Stream number and kind match for a chunk tag
    function automatic logic tag_selected(input logic [TAG_W-1:0] tag,
                                          input logic [7:0] wanted,
                                          input logic kind);
        t_hex hi;
        t_hex lo;
        logic kind_ok;
        hi = hex_digit(tag[7:0]);
        lo = hex_digit(tag[15:8]);
        if (kind == KIND_VIDEO) begin
            kind_ok = (tag[23:16] == CH_LC_D)
                   && (tag[31:24] == CH_LC_C || tag[31:24] == CH_LC_B);
        end else begin
            kind_ok = (tag[23:16] == CH_LC_W) && (tag[31:24] == CH_LC_B);
        end
        return hi.ok && lo.ok && ({hi.value, lo.value} == wanted) && kind_ok;
    endfunction

endpackage

@@ design/avi_movi_chunk_scanner_core.sv @@
// ----------------------------------------------------------------------------
// avi_movi_chunk_scanner_core
// Walks the byte stream of an AVI movi list and reports chunks of one stream.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                 payload
//  -------   ---------  ------------------------  ------------------------------
//  in        sink       i_in_valid / o_in_stall   i_data_byte
//  out       source     o_out_valid / i_out_stall o_event_code, o_chunk_tag,
//                                                 o_payload_length,
//                                                 o_payload_position,
//                                                 o_next_position
//  cfg       APB slave  psel/penable/pready       paddr, pwdata, prdata
//
//  One byte per cycle while o_in_stall is low; each byte is fully handled in
//  the cycle it is taken; its result, if any, is registered in the output stage.
//  A two-entry output stage (output register plus skid register) decouples
//  the sides: o_in_stall is the registered skid-full flag only.
//  Reset (i_rst_n low, synchronous) clears the parser state, the config
//  registers and both output valid flags; no clearing pass is needed.
//  After an end-of-stream or error transaction further bytes are taken and
//  dropped until reset.
//
//  Parsing: 8-byte little-endian headers (tag then size). LIST 'rec ' is
//  entered, other LISTs and unwanted chunks are skipped with their pad byte,
//  a wanted non-empty chunk yields a descriptor and its payload is skipped.
// ----------------------------------------------------------------------------
module avi_movi_chunk_scanner_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // byte input
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [7:0]                          i_data_byte,
    // result output
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [1:0]                          o_event_code,
    output logic [amcs_pkg::TAG_W-1:0]          o_chunk_tag,
    output logic [amcs_pkg::SIZE_W-1:0]         o_payload_length,
    output logic [amcs_pkg::FIELD_POS_W-1:0]    o_payload_position,
    output logic [amcs_pkg::FIELD_POS_W-1:0]    o_next_position,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [amcs_pkg::ADDR_W-1:0]         paddr,
    input  logic [amcs_pkg::DATA_W-1:0]         pwdata,
    output logic [amcs_pkg::DATA_W-1:0]         prdata,
    output logic                                pready
);

    // parser phases
    localparam logic [1:0] PH_HEADER   = 2'd0;
    localparam logic [1:0] PH_LISTTYPE = 2'd1;
    localparam logic [1:0] PH_SKIP     = 2'd2;

    localparam logic [2:0] HDR_LAST  = 3'd7;   // 8th header byte
    localparam logic [2:0] LIST_LAST = 3'd3;   // 4th list-type byte

    localparam int POS_W  = amcs_pkg::POS_W;
    localparam int SUM_W  = amcs_pkg::SUM_W;
    localparam int SKIP_W = amcs_pkg::SKIP_W;
    localparam int CMP_W  = amcs_pkg::CMP_W;

    // ---------------- configuration registers ----------------
    logic [7:0]                      r_wanted_stream;
    logic                            r_packet_kind;
    logic [amcs_pkg::CFG_POS_W-1:0]  r_movi_start;
    logic [amcs_pkg::CFG_POS_W-1:0]  r_movi_end;

    logic cfg_write;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_comb begin
        case (paddr[3:2])
            amcs_pkg::REG_WANTED_STREAM: prdata = amcs_pkg::DATA_W'(r_wanted_stream);
            amcs_pkg::REG_PACKET_KIND:   prdata = amcs_pkg::DATA_W'(r_packet_kind);
            amcs_pkg::REG_MOVI_START:    prdata = amcs_pkg::DATA_W'(r_movi_start);
            amcs_pkg::REG_MOVI_END:      prdata = amcs_pkg::DATA_W'(r_movi_end);
            default:                     prdata = '0;
        endcase
    end

    // ---------------- parser state ----------------
    logic [1:0]          r_phase,       n_phase;
    logic [63:0]         r_header,      n_header;
    logic [2:0]          r_hcount,      n_hcount;
    logic [31:0]         r_list_type,   n_list_type;
    logic [SKIP_W-1:0]   r_skip,        n_skip;
    logic [POS_W-1:0]    r_pos,         n_pos;
    logic                r_finished,    n_finished;
    logic                r_list_far,    n_list_far;   // LIST end beyond range

    // ---------------- output stage ----------------
    logic                r_out_valid,   n_out_valid;
    amcs_pkg::t_result   r_out,         n_out;
    logic                r_skid_valid,  n_skid_valid;
    amcs_pkg::t_result   r_skid,        n_skid;

    logic in_acc;
    assign o_in_stall = r_skid_valid;
    assign in_acc     = i_in_valid && !r_skid_valid;

    // ---------------- per-byte datapath ----------------
    logic [POS_W-1:0]          pos_inc;
    logic [63:0]               header_next;
    logic [31:0]               list_type_next;
    logic [amcs_pkg::TAG_W-1:0]  tag;
    logic [amcs_pkg::SIZE_W-1:0] size;
    logic                      pad;
    logic [SKIP_W-1:0]         padded;
    logic [SKIP_W-1:0]         list_skip;
    logic [SUM_W-1:0]          next_sum;
    logic                      far;
    logic                      selected;
    logic                      at_end;
    logic [SKIP_W-1:0]         skip_dec;
    logic                      res_valid;
    amcs_pkg::t_result         res;
    logic                      out_free;

    assign pos_inc        = r_pos + 1'b1;
    assign header_next    = {i_data_byte, r_header[63:8]};
    assign list_type_next = {i_data_byte, r_list_type[31:8]};
    assign tag            = header_next[31:0];
    assign size           = header_next[63:32];
    assign pad            = size[0];
    assign padded         = SKIP_W'(size) + SKIP_W'(pad);
    // size + pad - 4 for a LIST body that follows the list type
    assign list_skip      = SKIP_W'(size) - (pad ? SKIP_W'(3) : SKIP_W'(4));
    // first payload byte is pos_inc; padded end of the chunk
    assign next_sum       = SUM_W'(pos_inc) + SUM_W'(size) + SUM_W'(pad);
    assign far            = |next_sum[SUM_W-1:POS_W];
    assign selected       = amcs_pkg::tag_selected(tag, r_wanted_stream, r_packet_kind);
    assign at_end         = CMP_W'(r_pos) >= CMP_W'(r_movi_end);
    assign skip_dec       = (r_skip != '0) ? (r_skip - 1'b1) : r_skip;

    always_comb begin
        n_phase     = r_phase;
        n_header    = r_header;
        n_hcount    = r_hcount;
        n_list_type = r_list_type;
        n_skip      = r_skip;
        n_pos       = r_pos;
        n_finished  = r_finished;
        n_list_far  = r_list_far;
        res_valid   = 1'b0;
        res         = '0;

        if (in_acc && !r_finished) begin
            if (r_wanted_stream == amcs_pkg::NO_STREAM) begin
                n_finished     = 1'b1;
                res_valid      = 1'b1;
                res.event_code = amcs_pkg::EV_END;
            end else begin
                case (r_phase)
                    PH_SKIP: begin
                        n_pos  = pos_inc;
                        n_skip = skip_dec;
                        if (skip_dec == '0) begin
                            n_phase = PH_HEADER;
                        end
                    end
                    PH_LISTTYPE: begin
                        n_pos       = pos_inc;
                        n_list_type = list_type_next;
                        if (r_hcount == LIST_LAST) begin
                            n_hcount = '0;
                            n_phase  = PH_HEADER;
                            if (list_type_next != amcs_pkg::TAG_REC) begin
                                if (r_list_far) begin
                                    n_finished     = 1'b1;
                                    res_valid      = 1'b1;
                                    res.event_code = amcs_pkg::EV_RANGE;
                                end else if (r_skip != '0) begin
                                    n_phase = PH_SKIP;
                                end
                            end
                        end else begin
                            n_hcount = r_hcount + 1'b1;
                        end
                    end
                    PH_HEADER: begin
                        if (r_hcount == '0 && at_end) begin
                            n_finished     = 1'b1;
                            res_valid      = 1'b1;
                            res.event_code = amcs_pkg::EV_END;
                        end else begin
                            n_pos    = pos_inc;
                            n_header = header_next;
                            if (r_hcount == HDR_LAST) begin
                                n_hcount = '0;
                                if (tag == amcs_pkg::TAG_LIST) begin
                                    if (size < 32'd4) begin
                                        n_finished     = 1'b1;
                                        res_valid      = 1'b1;
                                        res.event_code = amcs_pkg::EV_FORMAT;
                                    end else begin
                                        n_list_type = '0;
                                        n_phase     = PH_LISTTYPE;
                                        n_skip      = list_skip;
                                        n_list_far  = far;
                                    end
                                end else if (selected && size == '0) begin
                                    // empty wanted chunk: nothing to report
                                    n_phase = PH_HEADER;
                                end else if (far) begin
                                    n_finished     = 1'b1;
                                    res_valid      = 1'b1;
                                    res.event_code = amcs_pkg::EV_RANGE;
                                end else begin
                                    n_skip = padded;
                                    if (padded != '0) begin
                                        n_phase = PH_SKIP;
                                    end
                                    if (selected) begin
                                        res_valid            = 1'b1;
                                        res.event_code       = amcs_pkg::EV_PACKET;
                                        res.chunk_tag        = tag;
                                        res.payload_length   = size;
                                        res.payload_position =
                                            amcs_pkg::FIELD_POS_W'(pos_inc);
                                        res.next_position    =
                                            amcs_pkg::FIELD_POS_W'(next_sum);
                                    end
                                end
                            end else begin
                                n_hcount = r_hcount + 1'b1;
                            end
                        end
                    end
                    default: begin
                        n_phase = PH_HEADER;
                    end
                endcase
            end
        end

        // writing movi_start also reloads the running offset
        if (cfg_write && paddr[3:2] == amcs_pkg::REG_MOVI_START) begin
            n_pos = POS_W'(pwdata[amcs_pkg::CFG_POS_W-1:0]);
        end
    end

    // output register with skid stage behind it
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (out_free) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out        = r_skid;
                n_skid_valid = res_valid;
                n_skid       = res;
            end else begin
                n_out_valid  = res_valid;
                n_out        = res;
            end
        end else if (res_valid) begin
            n_skid_valid = 1'b1;
            n_skid       = res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wanted_stream <= amcs_pkg::NO_STREAM;
            r_packet_kind   <= amcs_pkg::KIND_VIDEO;
            r_movi_start    <= '0;
            r_movi_end      <= '0;
            r_phase         <= PH_HEADER;
            r_header        <= '0;
            r_hcount        <= '0;
            r_list_type     <= '0;
            r_skip          <= '0;
            r_pos           <= '0;
            r_finished      <= 1'b0;
            r_list_far      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_skid_valid    <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_header     <= n_header;
            r_hcount     <= n_hcount;
            r_list_type  <= n_list_type;
            r_skip       <= n_skip;
            r_pos        <= n_pos;
            r_finished   <= n_finished;
            r_list_far   <= n_list_far;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
            if (cfg_write) begin
                case (paddr[3:2])
                    amcs_pkg::REG_WANTED_STREAM: r_wanted_stream <= pwdata[7:0];
                    amcs_pkg::REG_PACKET_KIND:   r_packet_kind   <= pwdata[0];
                    amcs_pkg::REG_MOVI_START:    r_movi_start    <=
                        pwdata[amcs_pkg::CFG_POS_W-1:0];
                    amcs_pkg::REG_MOVI_END:      r_movi_end <= pwdata[amcs_pkg::CFG_POS_W-1:0];
                    default: begin
                        r_movi_end <= r_movi_end;
                    end
                endcase
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out_valid        = r_out_valid;
    assign o_event_code       = r_out.event_code;
    assign o_chunk_tag        = r_out.chunk_tag;
    assign o_payload_length   = r_out.payload_length;
    assign o_payload_position = r_out.payload_position;
    assign o_next_position    = r_out.next_position;

`ifndef SYNTH
    // skid only fills behind a held output
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register valid with output register empty");

    // end/error is final until reset
    a_finished_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished |=> r_finished)
        else $error("finished flag dropped without reset");

    // skip phase always has bytes left and a fresh header count
    a_skip_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SKIP) |-> (r_skip != '0 && r_hcount == '0))
        else $error("skip phase with nothing to skip");

    // list type is four bytes
    a_list_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_LISTTYPE) |-> (r_hcount <= LIST_LAST))
        else $error("list type count overran");

    // a non-packet event only after the parser stopped
    a_stop_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.event_code != amcs_pkg::EV_PACKET) |-> r_finished)
        else $error("end or error event without finished state");
`endif

endmodule
